@@ hdl/mx86_pkg.sv @@
package mx86_pkg;

	localparam int XLEN   = 32;
	localparam int NREGS  = 8;
	localparam int RIDX_W = 3;
	localparam int LEN_W  = 4;

	// action codes of the incoming decoded instruction
	localparam logic [2:0] ACT_NOP = 3'd0;
	localparam logic [2:0] ACT_RET = 3'd1;
	localparam logic [2:0] ACT_JMP = 3'd2;
	localparam logic [2:0] ACT_MOV = 3'd3;
	localparam logic [2:0] ACT_ADD = 3'd4;
	localparam logic [2:0] ACT_SUB = 3'd5;

	// internal operation after classification
	typedef enum logic [2:0] {
		OP_STEP,
		OP_JMP,
		OP_MOV_IMM,
		OP_MOV_REG,
		OP_ADD,
		OP_SUB,
		OP_ERR
	} op_kind_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [RIDX_W-1:0]     dst;
		logic [RIDX_W-1:0]     src;
		logic [XLEN-1:0]       imm;
		logic [LEN_W-1:0]      len;
	} uop_t;

endpackage

@@ hdl/mx86_instr_if.sv @@
interface mx86_instr_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [2:0]  dst_reg;
	logic [2:0]  src_reg;
	logic        src_is_immediate;
	logic [31:0] immediate;
	logic [3:0]  instr_length;

	modport source (
		output valid, action, dst_reg, src_reg, src_is_immediate, immediate, instr_length,
		input  ready
	);
	modport sink (
		input  valid, action, dst_reg, src_reg, src_is_immediate, immediate, instr_length,
		output ready
	);
endinterface

@@ hdl/mx86_result_if.sv @@
interface mx86_result_if;
	logic        valid;
	logic        ready;
	logic        error;
	logic [31:0] next_ip;
	logic [31:0] written_value;
	logic        carry_out;
	logic        zero_out;
	logic        sign_out;

	modport source (
		output valid, error, next_ip, written_value, carry_out, zero_out, sign_out,
		input  ready
	);
	modport sink (
		input  valid, error, next_ip, written_value, carry_out, zero_out, sign_out,
		output ready
	);
endinterface

@@ hdl/mx86_ram.sv @@
module mx86_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ hdl/mx86_front.sv @@
module mx86_front (
	input  logic          clk,
	input  logic          arst_n,
	mx86_instr_if.sink    instr,
	output logic          push_valid,
	input  logic          push_ready,
	output mx86_pkg::uop_t push_uop
);
	import mx86_pkg::*;

	logic     valid_s1;
	uop_t     uop_s1;
	op_kind_t kind_c;

	always_comb begin
		unique case (instr.action) inside
			ACT_NOP, ACT_RET: kind_c = OP_STEP;
			ACT_JMP:          kind_c = OP_JMP;
			ACT_MOV:          kind_c = instr.src_is_immediate ? OP_MOV_IMM : OP_MOV_REG;
			ACT_ADD:          kind_c = instr.src_is_immediate ? OP_ERR : OP_ADD;
			ACT_SUB:          kind_c = instr.src_is_immediate ? OP_ERR : OP_SUB;
			default:          kind_c = OP_ERR;
		endcase
	end

	assign instr.ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (instr.ready && instr.valid) begin
			uop_s1.kind <= kind_c;
			uop_s1.dst  <= instr.dst_reg;
			uop_s1.src  <= instr.src_reg;
			uop_s1.imm  <= instr.immediate;
			uop_s1.len  <= instr.instr_length;
		end
	end

	assign push_valid = valid_s1;
	assign push_uop   = uop_s1;
endmodule

@@ hdl/mx86_queue.sv @@
// DEPTH must be at least 2.
module mx86_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  mx86_pkg::uop_t push_uop,
	output logic           pop_valid,
	input  logic           pop_ready,
	output mx86_pkg::uop_t pop_uop
);
	import mx86_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	uop_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_uop    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_uop;
		end
	end
endmodule

@@ hdl/mx86_back.sv @@
module mx86_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  mx86_pkg::uop_t pop_uop,
	mx86_result_if.source  result
);
	import mx86_pkg::*;

	// architectural state outside the register file
	logic [XLEN-1:0]   ip_q;
	logic              carry_q;
	logic              zero_q;
	logic              sign_q;
	logic [NREGS-1:0]  rf_vld_q;

	// execute stage
	logic              valid_s2;
	uop_t              uop_s2;
	logic              hit_a_s2;
	logic              hit_b_s2;
	logic              vld_a_s2;
	logic              vld_b_s2;
	logic [XLEN-1:0]   byp_s2;
	logic [XLEN-1:0]   rdata_a;
	logic [XLEN-1:0]   rdata_b;

	// output register
	logic              out_valid_q;
	logic              out_err_q;
	logic [XLEN-1:0]   out_ip_q;
	logic [XLEN-1:0]   out_wv_q;
	logic              out_c_q;
	logic              out_z_q;
	logic              out_s_q;

	logic              adv;
	logic              pop;
	logic [XLEN-1:0]   opa;
	logic [XLEN-1:0]   opb;
	logic [XLEN:0]     sum;
	logic [XLEN:0]     diff;
	logic [XLEN-1:0]   step_ip;
	logic              wr_c;
	logic              rf_we;
	logic [XLEN-1:0]   rf_wdata;
	logic              res_err;
	logic [XLEN-1:0]   res_ip;
	logic              res_c;
	logic              res_z;
	logic              res_s;

	assign adv       = valid_s2 && (!out_valid_q || result.ready);
	assign pop_ready = !valid_s2 || adv;
	assign pop       = pop_valid && pop_ready;

	// two copies of the register file, one per read port
	mx86_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (uop_s2.dst),
		.wdata (rf_wdata),
		.re    (pop),
		.raddr (pop_uop.dst),
		.rdata (rdata_a)
	);

	mx86_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (uop_s2.dst),
		.wdata (rf_wdata),
		.re    (pop),
		.raddr (pop_uop.src),
		.rdata (rdata_b)
	);

	// a write in the read cycle is not seen by the RAM read; forward it
	assign opa = hit_a_s2 ? byp_s2 : (vld_a_s2 ? rdata_a : '0);
	assign opb = hit_b_s2 ? byp_s2 : (vld_b_s2 ? rdata_b : '0);

	assign sum     = {1'b0, opa} + {1'b0, opb};
	assign diff    = {1'b0, opa} - {1'b0, opb};
	assign step_ip = ip_q + {{(XLEN-LEN_W){1'b0}}, uop_s2.len};

	always_comb begin
		res_err  = 1'b0;
		res_ip   = step_ip;
		wr_c     = 1'b0;
		rf_wdata = '0;
		res_c    = carry_q;
		res_z    = zero_q;
		res_s    = sign_q;
		unique case (uop_s2.kind)
			OP_STEP: begin
			end
			OP_JMP: begin
				res_ip = uop_s2.imm;
			end
			OP_MOV_IMM: begin
				wr_c     = 1'b1;
				rf_wdata = uop_s2.imm;
			end
			OP_MOV_REG: begin
				wr_c     = 1'b1;
				rf_wdata = opb;
			end
			OP_ADD: begin
				wr_c     = 1'b1;
				rf_wdata = sum[XLEN-1:0];
				res_c    = sum[XLEN];
				res_z    = (sum[XLEN-1:0] == '0);
				res_s    = sum[XLEN-1];
			end
			OP_SUB: begin
				wr_c     = 1'b1;
				rf_wdata = diff[XLEN-1:0];
				res_c    = diff[XLEN];
				res_z    = (diff[XLEN-1:0] == '0);
				res_s    = diff[XLEN-1];
			end
			default: begin
				res_err = 1'b1;
				res_ip  = ip_q;
			end
		endcase
	end

	assign rf_we = adv && wr_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			ip_q        <= '0;
			carry_q     <= 1'b0;
			zero_q      <= 1'b0;
			sign_q      <= 1'b0;
			rf_vld_q    <= '0;
		end else begin
			if (pop_ready) begin
				valid_s2 <= pop_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				ip_q        <= res_ip;
				carry_q     <= res_c;
				zero_q      <= res_z;
				sign_q      <= res_s;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (rf_we) begin
				rf_vld_q[uop_s2.dst] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			uop_s2   <= pop_uop;
			hit_a_s2 <= rf_we && (uop_s2.dst == pop_uop.dst);
			hit_b_s2 <= rf_we && (uop_s2.dst == pop_uop.src);
			vld_a_s2 <= rf_vld_q[pop_uop.dst];
			vld_b_s2 <= rf_vld_q[pop_uop.src];
			byp_s2   <= rf_wdata;
		end
		if (adv) begin
			out_err_q <= res_err;
			out_ip_q  <= res_ip;
			out_wv_q  <= rf_wdata;
			out_c_q   <= res_c;
			out_z_q   <= res_z;
			out_s_q   <= res_s;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.error         = out_err_q;
	assign result.next_ip       = out_ip_q;
	assign result.written_value = out_wv_q;
	assign result.carry_out     = out_c_q;
	assign result.zero_out      = out_z_q;
	assign result.sign_out      = out_s_q;

	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (uop_s2.kind == OP_ERR) |-> !rf_we && (rf_wdata == '0))
		else $error("error step writes the register file");

	a_err_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (uop_s2.kind == OP_ERR) |=> (ip_q == $past(ip_q)) && (carry_q == $past(carry_q))
			&& (zero_q == $past(zero_q)) && (sign_q == $past(sign_q)))
		else $error("error step changed pointer or flags");

	a_mov_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ((uop_s2.kind == OP_MOV_IMM) || (uop_s2.kind == OP_MOV_REG))
			|=> (carry_q == $past(carry_q)) && (zero_q == $past(zero_q))
			&& (sign_q == $past(sign_q)))
		else $error("mov changed the flags");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result.valid && (result.next_ip == ip_q) && (result.carry_out == carry_q))
		else $error("result beat disagrees with committed state");
endmodule

@@ hdl/mini_x86_execute_step_unit.sv @@
// Executes one already-decoded instruction of a small 32-bit x86 integer
// subset per beat: eight 32-bit registers (all zero after reset), an
// instruction pointer and carry, zero and sign flags. Every instruction
// beat on instr yields exactly one beat on result carrying the error bit,
// the pointer after the step, the value now in the destination register
// (zero when none was written) and the three flags. nop and ret advance
// the pointer by instr_length (ret does not pop), jmp loads the immediate
// as an absolute target, mov copies an immediate or register and keeps
// the flags, add and sub (register source only) write the result and set
// carry/borrow, zero and sign. add or sub with an immediate source and any
// other action code return error with all state untouched. Throughput is
// one instruction per clock while result.ready holds: a classify stage
// feeds a small queue, the register file is read on each pop from the
// queue (two RAM copies, one per operand port, with the write of the
// step before forwarded) and the execute stage commits. An accepted
// instruction beat passes the classify register, a queue slot, the
// execute stage and the output register to its result beat; a stalled
// result side backs up through the output register, the execute stage,
// QUEUE_DEPTH queue slots, the classify register, then instr.ready drops.
module mini_x86_execute_step_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	mx86_instr_if.sink    instr,
	mx86_result_if.source result
);
	import mx86_pkg::*;

	// front to queue
	logic push_valid;
	logic push_ready;
	uop_t push_uop;

	// queue to back end
	logic pop_valid;
	logic pop_ready;
	uop_t pop_uop;

	mx86_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.instr      (instr),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_uop   (push_uop)
	);

	mx86_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_uop   (push_uop),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_uop    (pop_uop)
	);

	mx86_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_uop   (pop_uop),
		.result    (result)
	);
endmodule
